>>> design/bek_pkg.sv
// Package: shared types, character constants and helpers for the entry key extractor.
`timescale 1ns / 1ps
package bek_pkg;

    localparam int unsigned LINE_W = 20;
    localparam int unsigned COL_W  = 12;
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = 2;

    localparam logic [LINE_W-1:0] LINE_SAT = 20'hFFFFF;
    localparam logic [COL_W-1:0]  COL_SAT  = 12'hFFF;

    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    localparam logic [63:0] TYPE_STRING   = 64'h0000_7374_7269_6E67;
    localparam logic [63:0] TYPE_COMMENT  = 64'h0063_6F6D_6D65_6E74;
    localparam logic [63:0] TYPE_PREAMBLE = 64'h7072_6561_6D62_6C65;

    typedef enum logic [2:0] {
        SM_LINE_START,
        SM_TYPE,
        SM_WAIT_BRACE,
        SM_KEY,
        SM_SKIP
    } t_scan_mode;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_SEND,
        BK_EMPTY
    } t_back_mode;

    typedef enum logic {
        CMD_STORE,
        CMD_EMIT
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op           op;
        logic [7:0]        data;
        logic [LINE_W-1:0] line;
        logic [COL_W-1:0]  column;
        logic              truncated;
    } t_cmd;

    typedef struct packed {
        logic push;
        t_cmd cmd;
    } t_push;

    function automatic logic bek_is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic bek_is_letter(input logic [7:0] c);
        logic [7:0] l;
        l = c | 8'h20;
        return (l >= 8'h61) && (l <= 8'h7A);
    endfunction

    function automatic logic bek_type_special(input logic [3:0] len, input logic [63:0] letters);
        return (len == 4'd6 && letters == TYPE_STRING)
            || (len == 4'd7 && letters == TYPE_COMMENT)
            || (len == 4'd8 && letters == TYPE_PREAMBLE);
    endfunction

endpackage

>>> design/bek_in_if.sv
// Interface: input text channel, one byte or line break per item.
`timescale 1ns / 1ps
interface bek_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       is_line_break;

    modport source (output valid, output char_code, output is_line_break, input ready);
    modport sink   (input valid, input char_code, input is_line_break, output ready);
endinterface

>>> design/bek_out_if.sv
// Interface: key result channel, one key byte or one empty-key marker per item.
`timescale 1ns / 1ps
interface bek_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  key_char;
    logic        key_last;
    logic        key_empty;
    logic [19:0] key_line;
    logic [11:0] key_column;
    logic        key_truncated;

    modport source (output valid, output key_char, output key_last, output key_empty,
                    output key_line, output key_column, output key_truncated, input ready);
    modport sink   (input valid, input key_char, input key_last, input key_empty,
                    input key_line, input key_column, input key_truncated, output ready);
endinterface

>>> design/bek_front.sv
// Front scanner: tracks position, parses entry headers and queues key commands.
`timescale 1ns / 1ps
module bek_front #(
    parameter int unsigned KEY_MAX = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bek_in_if.sink        i_in,
    input  logic          i_full,
    output bek_pkg::t_push o_push
);
    import bek_pkg::*;

    localparam int unsigned CW = $clog2(KEY_MAX + 1);
    localparam logic [CW-1:0] KMAX = CW'(KEY_MAX);

    t_scan_mode        r_mode, n_mode, mid_mode;
    logic [63:0]       r_letters, n_letters;
    logic [3:0]        r_type_len, n_type_len;
    logic [CW-1:0]     r_count, n_count;
    logic              r_ovf, n_ovf;
    logic              r_begun, n_begun;
    logic [LINE_W-1:0] r_start_line, n_start_line;
    logic [COL_W-1:0]  r_start_col, n_start_col;
    logic [LINE_W-1:0] r_line, n_line;
    logic [COL_W-1:0]  r_col, n_col;
    logic              accept;
    logic              special;
    logic [7:0]        c;
    logic              c_ws;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;
    assign c          = i_in.char_code;
    assign c_ws       = bek_is_ws(c);
    assign special    = bek_type_special(r_type_len, r_letters);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= SM_LINE_START;
            r_letters    <= '0;
            r_type_len   <= '0;
            r_count      <= '0;
            r_ovf        <= 1'b0;
            r_begun      <= 1'b0;
            r_start_line <= '0;
            r_start_col  <= '0;
            r_line       <= '0;
            r_col        <= '0;
        end else begin
            r_mode       <= n_mode;
            r_letters    <= n_letters;
            r_type_len   <= n_type_len;
            r_count      <= n_count;
            r_ovf        <= n_ovf;
            r_begun      <= n_begun;
            r_start_line <= n_start_line;
            r_start_col  <= n_start_col;
            r_line       <= n_line;
            r_col        <= n_col;
        end
    end

    always_comb begin
        n_mode       = r_mode;
        n_letters    = r_letters;
        n_type_len   = r_type_len;
        n_count      = r_count;
        n_ovf        = r_ovf;
        n_begun      = r_begun;
        n_start_line = r_start_line;
        n_start_col  = r_start_col;
        n_line       = r_line;
        n_col        = r_col;
        mid_mode     = r_mode;

        o_push.push          = 1'b0;
        o_push.cmd.op        = CMD_STORE;
        o_push.cmd.data      = c;
        o_push.cmd.line      = (r_start_line == LINE_SAT) ? LINE_SAT : r_start_line + 1'b1;
        o_push.cmd.column    = r_start_col;
        o_push.cmd.truncated = r_ovf;

        if (accept) begin
            if (i_in.is_line_break) begin
                case (r_mode)
                    SM_TYPE: begin
                        n_mode = (r_type_len != 4'd0 && !special) ? SM_WAIT_BRACE
                                                                   : SM_LINE_START;
                    end
                    SM_WAIT_BRACE, SM_KEY: begin
                    end
                    default: begin
                        n_mode = SM_LINE_START;
                    end
                endcase
                if (r_line != LINE_SAT) n_line = r_line + 1'b1;
                n_col = '0;
            end else begin
                // Close the type word on its first non-letter, then treat that byte below
                if (r_mode == SM_TYPE) begin
                    if (bek_is_letter(c)) begin
                        if (r_type_len < 4'd8) n_letters = {r_letters[55:0], c | 8'h20};
                        if (r_type_len < 4'd9) n_type_len = r_type_len + 1'b1;
                    end else if (r_type_len == 4'd0 || special) begin
                        mid_mode = SM_SKIP;
                    end else begin
                        mid_mode = SM_WAIT_BRACE;
                    end
                end
                n_mode = mid_mode;

                case (mid_mode)
                    SM_LINE_START: begin
                        if (c == CH_AT) begin
                            n_mode       = SM_TYPE;
                            n_letters    = '0;
                            n_type_len   = '0;
                            n_start_line = r_line;
                            n_start_col  = r_col;
                        end else if (!c_ws) begin
                            n_mode = SM_SKIP;
                        end
                    end
                    SM_WAIT_BRACE: begin
                        if (c == CH_LBRACE) begin
                            n_mode  = SM_KEY;
                            n_count = '0;
                            n_ovf   = 1'b0;
                            n_begun = 1'b0;
                        end else if (!c_ws) begin
                            n_mode = SM_SKIP;
                        end
                    end
                    SM_KEY: begin
                        if (c == CH_COMMA) begin
                            o_push.push   = 1'b1;
                            o_push.cmd.op = CMD_EMIT;
                            n_mode        = SM_SKIP;
                        end else begin
                            if (!r_begun) begin
                                n_begun      = 1'b1;
                                n_start_line = r_line;
                                n_start_col  = r_col;
                            end
                            // Drop leading whitespace; flag dropped non-whitespace text once the buffer is full
                            if (r_count == '0 && c_ws) begin
                            end else if (r_count < KMAX) begin
                                o_push.push = 1'b1;
                                n_count     = r_count + 1'b1;
                            end else if (!c_ws) begin
                                n_ovf = 1'b1;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
                if (r_col != COL_SAT) n_col = r_col + 1'b1;
            end
        end
    end

endmodule

>>> design/bek_queue.sv
// Command queue: short FIFO between the front scanner and the back emitter.
`timescale 1ns / 1ps
module bek_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bek_pkg::t_push i_push,
    input  logic           i_pop,
    output bek_pkg::t_cmd  o_cmd,
    output logic           o_full,
    output logic           o_empty
);
    import bek_pkg::*;

    t_cmd              r_slot [QDEPTH];
    logic [QPTR_W-1:0] r_wptr, r_rptr;
    logic [QPTR_W:0]   r_fill;
    logic              do_push, do_pop;

    assign o_full  = (r_fill == (QPTR_W + 1)'(QDEPTH));
    assign o_empty = (r_fill == '0);
    assign do_push = i_push.push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_slot[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_fill <= '0;
        end else begin
            if (do_push) r_wptr <= r_wptr + 1'b1;
            if (do_pop)  r_rptr <= r_rptr + 1'b1;
            case ({do_push, do_pop})
                2'b10:   r_fill <= r_fill + 1'b1;
                2'b01:   r_fill <= r_fill - 1'b1;
                default: r_fill <= r_fill;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_slot[r_wptr] <= i_push.cmd;
    end

endmodule

>>> design/bek_back.sv
// Back emitter: holds key bytes in a buffer and sends the trimmed key out.
`timescale 1ns / 1ps
module bek_back #(
    parameter int unsigned KEY_MAX = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  bek_pkg::t_cmd i_cmd,
    input  logic          i_empty,
    output logic          o_pop,
    bek_out_if.source     o_out
);
    import bek_pkg::*;

    localparam int unsigned CW = $clog2(KEY_MAX + 1);
    localparam int unsigned AW = $clog2(KEY_MAX);

    t_back_mode        r_mode, n_mode;
    logic [CW-1:0]     r_wptr, n_wptr;
    logic [CW-1:0]     r_trim, n_trim;
    logic [AW-1:0]     r_idx, n_idx;
    logic [LINE_W-1:0] r_line, n_line;
    logic [COL_W-1:0]  r_col, n_col;
    logic              r_trunc, n_trunc;

    logic [7:0]        r_mem [KEY_MAX];
    logic [7:0]        r_rd_data;
    logic              wr_en, rd_en;

    logic              r_ov, n_ov;
    logic [7:0]        r_o_char, n_o_char;
    logic              r_o_last, n_o_last;
    logic              r_o_empty, n_o_empty;
    logic [LINE_W-1:0] r_o_line, n_o_line;
    logic [COL_W-1:0]  r_o_col, n_o_col;
    logic              r_o_trunc, n_o_trunc;
    logic              out_free;
    logic              last_byte;

    assign out_free  = !r_ov || o_out.ready;
    assign last_byte = (({1'b0, r_idx} + 1'b1) == (AW + 1)'(r_trim));

    assign o_out.valid         = r_ov;
    assign o_out.key_char      = r_o_char;
    assign o_out.key_last      = r_o_last;
    assign o_out.key_empty     = r_o_empty;
    assign o_out.key_line      = r_o_line;
    assign o_out.key_column    = r_o_col;
    assign o_out.key_truncated = r_o_trunc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= BK_IDLE;
            r_wptr <= '0;
            r_trim <= '0;
            r_ov   <= 1'b0;
        end else begin
            r_mode <= n_mode;
            r_wptr <= n_wptr;
            r_trim <= n_trim;
            r_ov   <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_line    <= n_line;
        r_col     <= n_col;
        r_trunc   <= n_trunc;
        r_o_char  <= n_o_char;
        r_o_last  <= n_o_last;
        r_o_empty <= n_o_empty;
        r_o_line  <= n_o_line;
        r_o_col   <= n_o_col;
        r_o_trunc <= n_o_trunc;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[r_wptr[AW-1:0]] <= i_cmd.data;
        if (rd_en) r_rd_data <= r_mem[r_idx];
    end

    always_comb begin
        n_mode    = r_mode;
        n_wptr    = r_wptr;
        n_trim    = r_trim;
        n_idx     = r_idx;
        n_line    = r_line;
        n_col     = r_col;
        n_trunc   = r_trunc;
        n_ov      = r_ov && !o_out.ready;
        n_o_char  = r_o_char;
        n_o_last  = r_o_last;
        n_o_empty = r_o_empty;
        n_o_line  = r_o_line;
        n_o_col   = r_o_col;
        n_o_trunc = r_o_trunc;
        o_pop     = 1'b0;
        wr_en     = 1'b0;
        rd_en     = 1'b0;

        case (r_mode)
            BK_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    if (i_cmd.op == CMD_STORE) begin
                        wr_en  = 1'b1;
                        n_wptr = r_wptr + 1'b1;
                        // Trimmed length ends after the latest non-whitespace byte
                        if (!bek_is_ws(i_cmd.data)) n_trim = r_wptr + 1'b1;
                    end else begin
                        n_line  = i_cmd.line;
                        n_col   = i_cmd.column;
                        n_trunc = i_cmd.truncated;
                        n_idx   = '0;
                        n_mode  = (r_trim == '0) ? BK_EMPTY : BK_READ;
                    end
                end
            end
            BK_READ: begin
                rd_en  = 1'b1;
                n_mode = BK_SEND;
            end
            BK_SEND: begin
                if (out_free) begin
                    n_ov      = 1'b1;
                    n_o_char  = r_rd_data;
                    n_o_last  = last_byte;
                    n_o_empty = 1'b0;
                    n_o_line  = r_line;
                    n_o_col   = r_col;
                    n_o_trunc = r_trunc;
                    if (last_byte) begin
                        n_wptr = '0;
                        n_trim = '0;
                        n_mode = BK_IDLE;
                    end else begin
                        n_idx  = r_idx + 1'b1;
                        n_mode = BK_READ;
                    end
                end
            end
            BK_EMPTY: begin
                if (out_free) begin
                    n_ov      = 1'b1;
                    n_o_char  = 8'h00;
                    n_o_last  = 1'b1;
                    n_o_empty = 1'b1;
                    n_o_line  = r_line;
                    n_o_col   = r_col;
                    n_o_trunc = r_trunc;
                    n_wptr    = '0;
                    n_trim    = '0;
                    n_mode    = BK_IDLE;
                end
            end
            default: begin
                n_mode = BK_IDLE;
            end
        endcase
    end

endmodule

>>> design/bibtex_entry_key_extractor.sv
// Top level: entry key extractor, front scanner, command queue and key emitter.
//
//   channel  | dir | payload
//   ---------+-----+------------------------------------------------------------
//   i_in     | in  | char_code[7:0], is_line_break
//   o_out    | out | key_char[7:0], key_last, key_empty, key_line[19:0],
//            |     | key_column[11:0], key_truncated
//
// The front takes one input item per cycle while the command queue has room.
// Each kept key byte and each key end costs one queue slot; the emitter stores
// each key byte in its buffer and, once the key end arrives, sends each byte
// through a buffer read, then the output register.
// Input stalls only when the four-entry queue is full; the output register
// holds its item until taken. Reset is synchronous and needs no clearing pass.
`timescale 1ns / 1ps
module bibtex_entry_key_extractor #(
    parameter int unsigned KEY_MAX = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bek_in_if.sink    i_in,
    bek_out_if.source o_out
);
    import bek_pkg::*;

    t_push push;
    t_cmd  head;
    logic  full;
    logic  empty;
    logic  pop;

    bek_front #(.KEY_MAX(KEY_MAX)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push)
    );

    bek_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_cmd   (head),
        .o_full  (full),
        .o_empty (empty)
    );

    bek_back #(.KEY_MAX(KEY_MAX)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (head),
        .i_empty (empty),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule
